@@ sv/rms_layer_norm_macros.svh @@
// Assertion macros for the RMS layer normalisation block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef RMS_LAYER_NORM_MACROS_SVH
`define RMS_LAYER_NORM_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define RLN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset
`define RLN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RLN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define RLN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ sv/rln_pkg.sv @@
// Shared types and constants for the RMS layer normalisation block.
// No dependencies.
package rln_pkg;

  localparam int unsigned SUM_W      = 40;  // square sum, units of 2^-24
  localparam int unsigned CNT_W      = 7;   // sample count, up to 64
  localparam int unsigned LEN_W      = 7;   // row_length register
  localparam int unsigned EPS_W      = 16;  // epsilon register
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned A_W        = 41;  // mean square before normalising
  localparam int unsigned Y_W        = 32;  // Q2.30 reciprocal root
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned SH_W       = 6;   // output shift, 31..51
  localparam int unsigned DIV_CNT_W  = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_LENGTH = 2'd0,
    REG_EPSILON    = 2'd1
  } cfg_reg_e;

  // One closed row handed from front to back
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum;
    logic [EPS_W-1:0] eps;
  } rln_job_t;

  typedef enum logic [3:0] {
    B_IDLE, B_DIV, B_NORM, B_SEED, B_SQ, B_TA, B_F, B_YF,
    B_RD, B_MUL1, B_MUL2, B_EMIT
  } back_state_e;

endpackage

@@ sv/rln_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rln_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/rln_front.sv @@
// Front end: takes items, writes the row buffer, sums squares, closes rows.
// Depends on rln_pkg.
module rln_front import rln_pkg::*; #(
  parameter int unsigned MAX_ROW     = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [SAMPLE_BITS-1:0]       sample_value_i,
  input  logic signed [SAMPLE_BITS-1:0]       gain_value_i,
  input  logic                                cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                cfg_index_i,
  input  logic [CFG_DATA_W-1:0]               cfg_data_i,
  output logic                                ram_we_o,
  output logic [$clog2(MAX_ROW):0]            ram_addr_o,
  output logic [2*SAMPLE_BITS-1:0]            ram_data_o,
  output logic                                push_o,
  output rln_job_t                            job_o,
  input  logic                                row_free_i
);

  localparam int unsigned AW    = $clog2(MAX_ROW);
  localparam int unsigned SQ_W  = 2 * SAMPLE_BITS;
  localparam int unsigned ACC_W = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;

  logic [LEN_W-1:0] row_len_q;
  logic [EPS_W-1:0] eps_q;
  logic [CNT_W-1:0] fill_q;
  logic [SUM_W-1:0] sum_q;
  logic             bank_q;
  logic [1:0]       rows_q;

  logic               accept;
  logic [LEN_W-1:0]   len_eff;
  logic [CNT_W-1:0]   fill_next;
  logic               close;
  logic signed [SQ_W-1:0] sq_s;
  logic [ACC_W-1:0]   sum_ext;
  logic [SUM_W-1:0]   sum_new;

  // Two rows may be outstanding, one per buffer bank
  assign busy   = (rows_q == 2'd2);
  assign accept = start && !busy;

  // Effective row length
  always_comb begin
    if (row_len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (row_len_q > LEN_W'(MAX_ROW)) begin
      len_eff = LEN_W'(MAX_ROW);
    end else begin
      len_eff = row_len_q;
    end
  end

  assign fill_next = fill_q + CNT_W'(1);
  assign close     = accept && (fill_next >= len_eff);

  // Saturating square accumulation
  assign sq_s    = sample_value_i * sample_value_i;
  assign sum_ext = ACC_W'(sum_q) + ACC_W'($unsigned(sq_s));
  assign sum_new = (sum_ext > ACC_W'({SUM_W{1'b1}})) ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];

  assign ram_we_o   = accept;
  assign ram_addr_o = {bank_q, fill_q[AW-1:0]};
  assign ram_data_o = {sample_value_i, gain_value_i};

  assign push_o      = close;
  assign job_o.bank  = bank_q;
  assign job_o.count = fill_next;
  assign job_o.sum   = sum_new;
  assign job_o.eps   = eps_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q <= LEN_W'(16);
      eps_q     <= EPS_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ROW_LENGTH: row_len_q <= cfg_data_i[LEN_W-1:0];
        REG_EPSILON:    eps_q     <= cfg_data_i[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Row fill and bank control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      sum_q  <= '0;
      bank_q <= 1'b0;
    end else if (accept) begin
      if (close) begin
        fill_q <= '0;
        sum_q  <= '0;
        bank_q <= !bank_q;
      end else begin
        fill_q <= fill_next;
        sum_q  <= sum_new;
      end
    end
  end

  // Rows closed but not yet fully emitted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= '0;
    end else if (close && !row_free_i) begin
      rows_q <= rows_q + 2'd1;
    end else if (!close && row_free_i) begin
      rows_q <= rows_q - 2'd1;
    end
  end

endmodule

@@ sv/rln_queue.sv @@
// Two-entry job queue between front and back.
// Depends on rln_pkg.
module rln_queue import rln_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  rln_job_t job_i,
  input  logic     pop_i,
  output logic     valid_o,
  output rln_job_t job_o
);

  rln_job_t   slot_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] count_q;

  assign valid_o = (count_q != 2'd0);
  assign job_o   = slot_q[rd_q];

  // Payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

@@ sv/rln_back.sv @@
// Back end: mean square division, reciprocal square root by Newton steps,
// and the per-sample scale, round and saturate. Depends on rln_pkg, macros.
`include "rms_layer_norm_macros.svh"
module rln_back import rln_pkg::*; #(
  parameter int unsigned MAX_ROW      = 64,
  parameter int unsigned SAMPLE_BITS  = 16,
  parameter int unsigned NEWTON_STEPS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  rln_job_t                      job_i,
  output logic                          pop_o,
  output logic [$clog2(MAX_ROW):0]      rd_addr_o,
  input  logic [2*SAMPLE_BITS-1:0]      rd_data_i,
  output logic                          result_valid_o,
  output logic signed [SAMPLE_BITS-1:0] normalized_value_o,
  output logic                          row_done_o,
  output logic                          row_free_o
);

  localparam int unsigned AW     = $clog2(MAX_ROW);
  localparam int unsigned SG_W   = 2 * SAMPLE_BITS;
  localparam int unsigned STEP_W = $clog2(NEWTON_STEPS);
  localparam logic [PROD_W-1:0] POS_MAX = PROD_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [PROD_W-1:0] THREE_Q30 = PROD_W'(64'd3 << 30);

  back_state_e state_q, state_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic              bank_q, bank_d;
  logic [EPS_W-1:0]  eps_q, eps_d;
  logic [SUM_W-1:0]  quot_q, quot_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [A_W-1:0]    a_q, a_d;
  logic [SH_W-1:0]   sh_q, sh_d;
  logic [Y_W-1:0]    y_q, y_d;
  logic [Y_W-1:0]    f_q, f_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic signed [SG_W-1:0] sg_q, sg_d;
  logic              neg_q, neg_d;
  logic              out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0] out_val_q, out_val_d;
  logic              out_done_q, out_done_d;

  // Datapath helpers
  logic [CNT_W:0]    rem_sh;
  logic              rem_ge;
  logic [A_W-1:0]    mean_sq;
  logic [33:0]       nine_a;
  logic [33:0]       t_val;
  logic [SG_W-1:0]   mag;
  logic [PROD_W-1:0] rnd_sum;
  logic [PROD_W-1:0] r_val;
  logic [PROD_W-1:0] y_prod;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic signed [SAMPLE_BITS-1:0] gn;
  logic              last;

  assign rem_sh  = {rem_q, quot_q[SUM_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, n_q});
  assign mean_sq = A_W'({quot_q[SUM_W-2:0], rem_ge}) + A_W'(eps_q);
  assign nine_a  = 34'(a_q[29:0]) * 34'd9;
  assign t_val   = prod_q[63:30];
  assign mag     = sg_q[SG_W-1] ? SG_W'(-sg_q) : SG_W'(sg_q);
  assign rnd_sum = prod_q + (PROD_W'(1) << (sh_q - SH_W'(1)));
  assign r_val   = rnd_sum >> sh_q;
  assign y_prod  = PROD_W'(y_q) * PROD_W'(f_q);
  assign smp     = rd_data_i[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign gn      = rd_data_i[SAMPLE_BITS-1:0];
  assign last    = (idx_q == n_q - CNT_W'(1));

  assign rd_addr_o          = {bank_q, idx_q[AW-1:0]};
  assign result_valid_o     = out_valid_q;
  assign normalized_value_o = out_val_q;
  assign row_done_o         = out_done_q;

  // Sequencer: next state and datapath updates
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    bank_d      = bank_q;
    eps_d       = eps_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    a_d         = a_q;
    sh_d        = sh_q;
    y_d         = y_q;
    f_d         = f_q;
    prod_d      = prod_q;
    step_d      = step_q;
    idx_d       = idx_q;
    sg_d        = sg_q;
    neg_d       = neg_q;
    out_valid_d = 1'b0;
    out_val_d   = out_val_q;
    out_done_d  = out_done_q;
    pop_o       = 1'b0;
    row_free_o  = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (job_valid_i) begin
          pop_o   = 1'b1;
          n_d     = job_i.count;
          bank_d  = job_i.bank;
          eps_d   = job_i.eps;
          quot_d  = job_i.sum;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = B_DIV;
        end
      end
      // Restoring division, one quotient bit a cycle
      B_DIV: begin
        rem_d  = rem_ge ? CNT_W'(rem_sh - {1'b0, n_q}) : rem_sh[CNT_W-1:0];
        quot_d = {quot_q[SUM_W-2:0], rem_ge};
        cnt_d  = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
          a_d     = (mean_sq == '0) ? A_W'(1) : mean_sq;
          sh_d    = SH_W'(45);
          state_d = B_NORM;
        end
      end
      // Even shift into [1/4, 1) of Q0.30
      B_NORM: begin
        if (a_q < A_W'(1 << 28)) begin
          a_d  = a_q << 2;
          sh_d = sh_q - SH_W'(1);
        end else if (a_q >= A_W'(1 << 30)) begin
          a_d  = a_q >> 2;
          sh_d = sh_q + SH_W'(1);
        end else begin
          state_d = B_SEED;
        end
      end
      B_SEED: begin
        y_d     = Y_W'(32'd2281701376) - Y_W'(nine_a[33:3]);
        step_d  = '0;
        state_d = B_SQ;
      end
      B_SQ: begin
        prod_d  = PROD_W'(y_q) * PROD_W'(y_q);
        state_d = B_TA;
      end
      B_TA: begin
        prod_d  = PROD_W'(a_q[29:0]) * PROD_W'(prod_q[63:30]);
        state_d = B_F;
      end
      B_F: begin
        f_d     = (PROD_W'(t_val) >= THREE_Q30) ? '0 : Y_W'(THREE_Q30 - PROD_W'(t_val));
        state_d = B_YF;
      end
      B_YF: begin
        y_d    = y_prod[62:31];
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(NEWTON_STEPS - 1)) begin
          idx_d   = '0;
          state_d = B_RD;
        end else begin
          state_d = B_SQ;
        end
      end
      // Per-sample output loop
      B_RD: begin
        state_d = B_MUL1;
      end
      B_MUL1: begin
        sg_d    = smp * gn;
        state_d = B_MUL2;
      end
      B_MUL2: begin
        neg_d   = sg_q[SG_W-1];
        prod_d  = PROD_W'(mag) * PROD_W'(y_q);
        state_d = B_EMIT;
      end
      B_EMIT: begin
        out_valid_d = 1'b1;
        out_done_d  = last;
        if (neg_q) begin
          out_val_d = (r_val > POS_MAX + PROD_W'(1)) ?
                      SAMPLE_BITS'(-(POS_MAX + PROD_W'(1))) : SAMPLE_BITS'(-r_val);
        end else begin
          out_val_d = (r_val > POS_MAX) ? SAMPLE_BITS'(POS_MAX) : SAMPLE_BITS'(r_val);
        end
        if (last) begin
          row_free_o = 1'b1;
          state_d    = B_IDLE;
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = B_RD;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // State and output strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    bank_q     <= bank_d;
    eps_q      <= eps_d;
    quot_q     <= quot_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    a_q        <= a_d;
    sh_q       <= sh_d;
    y_q        <= y_d;
    f_q        <= f_d;
    prod_q     <= prod_d;
    step_q     <= step_d;
    idx_q      <= idx_d;
    sg_q       <= sg_d;
    neg_q      <= neg_d;
    out_val_q  <= out_val_d;
    out_done_q <= out_done_d;
  end

  `RLN_ASSERT_NXT(a_strobe_single, clk_i, rst_ni, out_valid_q, !out_valid_q, "result strobe held for two cycles")
  `RLN_ASSERT_NXT(a_free_marks_last, clk_i, rst_ni, row_free_o, out_valid_q && out_done_q, "row release without last result")
  `RLN_ASSERT_IMP(a_norm_range, clk_i, rst_ni, state_q == B_SEED, (a_q >= A_W'(1 << 28)) && (a_q < A_W'(1 << 30)), "seed taken from unnormalised mean square")

endmodule

@@ sv/rms_layer_norm.sv @@
// Top level of the RMS layer normalisation block.
// Depends on rln_pkg, rln_front, rln_queue, rln_back and rln_ram.
//
//  port group   direction  handshake            payload
//  item in      in         start / busy         sample_value_i, gain_value_i
//  result out   out        result_valid_o       normalized_value_o, row_done_o
//  config       in         cfg_we_i             cfg_index_i, cfg_data_i
//
// An item is taken whenever start is high and busy is low; a row of n closes on
// its last item. Per row the back end takes the job, divides the square sum by the
// count, normalises, refines the reciprocal root, then emits one sample at a time.
// Two row buffers let the next row fill while the previous one is emitted;
// busy rises only when both are taken. Results cannot be stalled.
// Reset clears control state; buffer contents are not cleared.
module rms_layer_norm import rln_pkg::*; #(
  parameter int unsigned MAX_ROW      = 64,
  parameter int unsigned SAMPLE_BITS  = 16,
  parameter int unsigned NEWTON_STEPS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] sample_value_i,
  input  logic signed [SAMPLE_BITS-1:0] gain_value_i,
  output logic                          result_valid_o,
  output logic signed [SAMPLE_BITS-1:0] normalized_value_o,
  output logic                          row_done_o,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_ROW);

  logic                     ram_we;
  logic [AW:0]              ram_wr_addr;
  logic [2*SAMPLE_BITS-1:0] ram_wr_data;
  logic [AW:0]              ram_rd_addr;
  logic [2*SAMPLE_BITS-1:0] ram_rd_data;
  logic                     push;
  logic                     pop;
  logic                     job_valid;
  logic                     row_free;
  rln_job_t                 job_in;
  rln_job_t                 job_out;

  rln_front #(
    .MAX_ROW     (MAX_ROW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .sample_value_i (sample_value_i),
    .gain_value_i   (gain_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .ram_we_o       (ram_we),
    .ram_addr_o     (ram_wr_addr),
    .ram_data_o     (ram_wr_data),
    .push_o         (push),
    .job_o          (job_in),
    .row_free_i     (row_free)
  );

  // Row buffer: two banks of sample and gain pairs
  rln_ram #(
    .WIDTH (2 * SAMPLE_BITS),
    .DEPTH (2 << AW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  rln_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  rln_back #(
    .MAX_ROW      (MAX_ROW),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .NEWTON_STEPS (NEWTON_STEPS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .job_valid_i        (job_valid),
    .job_i              (job_out),
    .pop_o              (pop),
    .rd_addr_o          (ram_rd_addr),
    .rd_data_i          (ram_rd_data),
    .result_valid_o     (result_valid_o),
    .normalized_value_o (normalized_value_o),
    .row_done_o         (row_done_o),
    .row_free_o         (row_free)
  );

endmodule

@@ sim/tb.sv @@
// Testbench for rms_layer_norm: drives rows of sample/gain items, predicts each
// normalised result and checks them in order. Depends on rln_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rln_pkg::*;

  localparam int unsigned MAX_ROW = 64;
  localparam logic [39:0] SUM_MAX = 40'hFF_FFFF_FFFF;

  typedef struct {
    logic signed [15:0] value;
    logic               last;
  } norm_result_t;

  // Scoreboard: own copy of the row state and registers
  class norm_scoreboard;
    logic [6:0]         row_len;
    logic [15:0]        eps;
    logic signed [15:0] smp_buf [MAX_ROW];
    logic signed [15:0] gain_buf[MAX_ROW];
    logic [39:0]        sq_sum;
    int unsigned        fill;
    norm_result_t       pending[$];
    int unsigned        errors;

    function void clear();
      row_len = 7'd16; eps = 16'd1; sq_sum = '0; fill = 0;
      pending.delete(); errors = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [15:0] d);
      if (idx == REG_ROW_LENGTH) row_len = d[6:0];
      else if (idx == REG_EPSILON) eps = d;
    endfunction

    // Q2.30 reciprocal root of m (units 2^-24), plus even-shift count
    function automatic logic [63:0] rsqrt(logic [63:0] m, output int s);
      logic [63:0] a, y, y2, t, f;
      a = (m == 0) ? 64'd1 : m;
      s = 0;
      while (a < (64'd1 << 28)) begin a = a << 2; s++; end
      while (a >= (64'd1 << 30)) begin a = a >> 2; s--; end
      y = (64'd17 << 27) - ((64'd9 * a) >> 3);
      for (int k = 0; k < 4; k++) begin
        y2 = (y * y) >> 30;
        t  = (a * y2) >> 30;
        f  = (t >= 64'd3 << 30) ? 64'd0 : ((64'd3 << 30) - t);
        y  = (y * f) >> 31;
      end
      return y;
    endfunction

    function void note_item(logic signed [15:0] s, logic signed [15:0] g);
      logic [63:0] sq, m, y, mag, p, r;
      int sh, sf, len;
      longint sg;
      norm_result_t res;
      if (fill < MAX_ROW) begin smp_buf[fill] = s; gain_buf[fill] = g; fill++; end
      sq = 64'(longint'(s) * longint'(s));
      if ({24'd0, sq_sum} > {24'd0, SUM_MAX} - sq) sq_sum = SUM_MAX;
      else sq_sum = sq_sum + sq[39:0];
      len = (row_len == 0) ? 1 : (row_len > MAX_ROW ? MAX_ROW : row_len);
      if (fill < len) return;
      m = {24'd0, sq_sum} / fill + eps;
      y = rsqrt(m, sf);
      sh = 45 - sf;
      for (int k = 0; k < fill; k++) begin
        sg = longint'(smp_buf[k]) * longint'(gain_buf[k]);
        mag = (sg < 0) ? 64'(-sg) : 64'(sg);
        p = mag * y;
        r = (p + (64'd1 << (sh - 1))) >> sh;
        if (sg < 0) begin
          if (r > 32768) r = 32768;
          res.value = 16'(-r);
        end else begin
          if (r > 32767) r = 32767;
          res.value = 16'(r);
        end
        res.last = (k == fill - 1);
        pending = {pending, res};
      end
      fill = 0; sq_sum = '0;
    endfunction

    function void check(logic signed [15:0] v, logic last, realtime t);
      norm_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value %0d last %0b", t, v, last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.value !== v) begin
        $display("%0t: normalized_value expected %0d actual %0d", t, e.value, v);
        errors++;
      end
      if (e.last !== last) begin
        $display("%0t: row_done expected %0b actual %0b", t, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni, start, busy, result_valid_o, row_done_o, cfg_we_i;
  logic signed [15:0] sample_value_i, gain_value_i, normalized_value_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  norm_scoreboard sb;

  rms_layer_norm u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  // Result checker; results cannot be held off
  always @(posedge clk_i)
    if (rst_ni && result_valid_o) sb.check(normalized_value_o, row_done_o, $realtime);

  // Start stays high between items of a burst; gaps and drains drop it
  task automatic put_item(logic signed [15:0] s, logic signed [15:0] g);
    start <= 1'b1; sample_value_i <= s; gain_value_i <= g;
    do @(posedge clk_i); while (busy);
    sb.note_item(s, g);
  endtask

  // Gap between bursts; a burst length counter decides when one falls
  int burst_left = 0;
  task automatic maybe_gap();
    int gap;
    if (burst_left > 0) begin burst_left--; return; end
    burst_left = $urandom_range(0, 20);
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_reg(cfg_reg_e idx, logic [15:0] d);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= d;
    @(posedge clk_i);
    sb.write_reg(idx, d);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(0, 8191)) - 4096);
      3: return 16'h1000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int n;
    sb = new();
    sb.clear();
    rst_ni = 1'b0; start = 1'b0; sample_value_i = '0; gain_value_i = '0;
    cfg_we_i = 1'b0; cfg_index_i = REG_ROW_LENGTH; cfg_data_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: row of one, extremes, zero mean square
    set_reg(REG_ROW_LENGTH, 16'd1);
    set_reg(REG_EPSILON, 16'd0);
    put_item(16'sh7FFF, 16'sh7FFF);
    put_item(16'sh8000, 16'sh7FFF);
    put_item(16'sh0000, 16'sh1000);
    put_item(16'sh8000, 16'sh8000);
    drain();
    set_reg(REG_EPSILON, 16'hFFFF);
    put_item(16'sh0001, 16'sh1000);
    put_item(16'sh0000, 16'sh0000);
    drain();
    // Row length zero, then above the maximum
    set_reg(REG_ROW_LENGTH, 16'd0);
    put_item(16'sh1234, 16'sh8000);
    drain();
    set_reg(REG_ROW_LENGTH, 16'd127);
    set_reg(REG_EPSILON, 16'd1);
    for (int i = 0; i < 64; i++) put_item(16'sh7FFF, 16'(i * 1000));
    drain();
    // Row length lowered mid-row
    set_reg(REG_ROW_LENGTH, 16'd8);
    repeat (5) put_item(16'sh0800, 16'sh1000);
    drain();
    set_reg(REG_ROW_LENGTH, 16'd3);
    put_item(16'shF000, 16'sh7FFF);
    drain();

    // Random phases with varied settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: n = $urandom_range(1, 4);
        1: n = $urandom_range(5, 16);
        2: n = 64;
        default: n = $urandom_range(1, 64);
      endcase
      set_reg(REG_ROW_LENGTH, 16'(n));
      set_reg(REG_EPSILON, (ph % 3 == 0) ? 16'hFFFF : 16'($urandom));
      for (int i = 0; i < 36; i++) begin
        put_item(rand_field(), rand_field());
        maybe_gap();
        if (i == 20) drain();  // pause until all results are back
      end
      // Finish the open row so the phase ends idle
      while (sb.fill != 0) put_item(rand_field(), rand_field());
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
